// ===== src/rmts_pkg.sv =====
package rmts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int TIME_BITS = 32;
  localparam int SLOT_BITS = $clog2(MAX_TASKS);
  localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  typedef struct packed {
    logic [15:0]          period;
    logic [15:0]          exec_time;
    logic [TIME_BITS-1:0] release_time;
    logic [15:0]          executed;
  } slot_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] idx;
    slot_t                data;
  } slot_wr_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] sum;
    logic                 released;
    logic                 overdue;
  } alu_res_t;

endpackage

// ===== src/rmts_slot_file.sv =====
module rmts_slot_file (
  input  logic                           clk,
  input  logic [rmts_pkg::SLOT_BITS-1:0] rd_idx,
  output rmts_pkg::slot_t                rd,
  input  rmts_pkg::slot_wr_t             wr
);

  rmts_pkg::slot_t slots [rmts_pkg::MAX_TASKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slots[wr.idx] <= wr.data;
    end
  end

  assign rd = slots[rd_idx];

endmodule

// ===== src/rmts_alu.sv =====
module rmts_alu (
  input  logic [rmts_pkg::TIME_BITS-1:0] release_time,
  input  logic [15:0]                    period,
  input  logic [rmts_pkg::TIME_BITS-1:0] time_now,
  output rmts_pkg::alu_res_t             res
);

  logic [rmts_pkg::TIME_BITS-1:0] sum;

  assign sum          = release_time + rmts_pkg::TIME_BITS'(period);
  assign res.sum      = sum;
  assign res.released = (release_time <= time_now);
  assign res.overdue  = (sum < time_now);

endmodule

// ===== src/rate_monotonic_tick_scheduler_unit.sv =====
// Rate-monotonic tick scheduler.
// Input channel (in_valid/in_ready) carries one transaction per item: a load
// (action = 1) writes period and execution time of task_slot, sets its release
// to the current time and clears its executed count; a tick (action = 0)
// schedules one time unit and yields one result on the output channel
// (out_valid/out_ready): tick_time, ran_valid, ran_task, job_done, missed_mask.
// cfg_we/cfg_wdata write active_tasks (slots 0 to min(active_tasks,8)-1 take part).
// A load is absorbed in the accept cycle and the block stays ready.
// A tick runs on one shared add/compare unit: a priority scan over the
// participating slots, a step to charge the chosen task, a deadline scan
// over the slots, and a step to post the result. No new transaction is
// taken until the result is posted. With no slot taking part both scans
// and the charge step are skipped and the result is posted directly.
// The output register holds the result while the receiver stalls; the block
// keeps it and waits in its final step until the register frees up.
// Reset (rst, synchronous) clears time to 0, active_tasks to 1 and the
// handshake; slot contents are undefined until loaded.
module rate_monotonic_tick_scheduler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [2:0]  task_slot,
  input  logic [15:0] period_in,
  input  logic [15:0] exec_time_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] tick_time,
  output logic        ran_valid,
  output logic [2:0]  ran_task,
  output logic        job_done,
  output logic [7:0]  missed_mask
);

  localparam int SB = rmts_pkg::SLOT_BITS;
  localparam int CB = rmts_pkg::CNT_BITS;
  localparam int TB = rmts_pkg::TIME_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SELECT = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_MISS   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]    state;
  logic [3:0]    active_tasks;
  logic [TB-1:0] time_now;
  logic [SB-1:0] idx;
  logic [SB-1:0] pick;
  logic          found;
  logic [15:0]   best_period;
  logic          done_flag;
  logic [7:0]    missed;

  logic [CB-1:0]      n_part;
  logic               last;
  logic               accept;
  logic [SB-1:0]      rd_idx;
  rmts_pkg::slot_t    rd;
  rmts_pkg::slot_wr_t wr;
  rmts_pkg::alu_res_t alu;
  logic [15:0]        exec_inc;
  logic               hit;

  assign n_part = (32'(active_tasks) > rmts_pkg::MAX_TASKS) ?
                  CB'(rmts_pkg::MAX_TASKS) : CB'(active_tasks);
  assign last   = ((32'(idx) + 1) >= 32'(n_part));
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_idx   = (state == ST_EXEC) ? pick : idx;

  rmts_slot_file u_slots (
    .clk    (clk),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

  rmts_alu u_alu (
    .release_time (rd.release_time),
    .period       (rd.period),
    .time_now     (time_now),
    .res          (alu)
  );

  assign exec_inc = rd.executed + 16'd1;
  assign hit      = (exec_inc == rd.exec_time);

  always_comb begin
    wr      = '0;
    wr.idx  = rd_idx;
    wr.data = rd;
    unique case (state)
      ST_IDLE: begin
        wr.en                = accept && (action == rmts_pkg::ACTION_LOAD) &&
                               (32'(task_slot) < rmts_pkg::MAX_TASKS);
        wr.idx               = SB'(task_slot);
        wr.data.period       = period_in;
        wr.data.exec_time    = exec_time_in;
        wr.data.release_time = time_now;
        wr.data.executed     = '0;
      end
      ST_EXEC: begin
        wr.en                = found;
        wr.data.release_time = hit ? alu.sum : rd.release_time;
        wr.data.executed     = hit ? 16'd0 : exec_inc;
      end
      ST_MISS: begin
        wr.en                = alu.overdue;
        wr.data.release_time = alu.sum;
        wr.data.executed     = '0;
      end
      ST_SELECT, ST_DONE: begin
        wr.en = 1'b0;
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_tasks <= 4'd1;
      time_now     <= '0;
      out_valid    <= 1'b0;
      idx          <= '0;
      found        <= 1'b0;
      done_flag    <= 1'b0;
      missed       <= '0;
    end else begin
      if (cfg_we) begin
        active_tasks <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (action == rmts_pkg::ACTION_TICK)) begin
            idx       <= '0;
            found     <= 1'b0;
            done_flag <= 1'b0;
            missed    <= '0;
            state     <= (n_part == '0) ? ST_DONE : ST_SELECT;
          end
        end
        ST_SELECT: begin
          if (alu.released && (!found || (rd.period < best_period))) begin
            found       <= 1'b1;
            pick        <= idx;
            best_period <= rd.period;
          end
          if (last) begin
            idx   <= '0;
            state <= ST_EXEC;
          end else begin
            idx <= idx + SB'(1);
          end
        end
        ST_EXEC: begin
          done_flag <= found && hit;
          state     <= ST_MISS;
        end
        ST_MISS: begin
          if (alu.overdue) begin
            missed <= missed | (8'd1 << idx);
          end
          if (last) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + SB'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            tick_time   <= time_now[31:0];
            ran_valid   <= found;
            ran_task    <= found ? 3'(pick) : 3'd0;
            job_done    <= done_flag;
            missed_mask <= missed;
            time_now    <= time_now + TB'(1);
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
